// ===== hdl/uqt_pkg.sv =====
// Package for the URL query tokenizer: byte codes, phase and status
// encodings, and the structs passed between the decoder and the top level.
// No dependencies.
`default_nettype none

package uqt_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned KindW   = 2;
    localparam int unsigned StatusW = 3;

    localparam logic [CharW-1:0] CHR_QMARK = 8'h3F;  // '?'
    localparam logic [CharW-1:0] CHR_AMP   = 8'h26;  // '&'
    localparam logic [CharW-1:0] CHR_EQ    = 8'h3D;  // '='
    localparam logic [CharW-1:0] CHR_LF    = 8'h0A;  // newline
    localparam logic [CharW-1:0] CHR_CR    = 8'h0D;  // carriage return

    typedef enum logic [1:0] {
        PH_PATH  = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2,
        PH_SKIP  = 2'd3
    } t_phase;

    typedef enum logic [KindW-1:0] {
        KIND_NONE  = 2'd0,
        KIND_PATH  = 2'd1,
        KIND_NAME  = 2'd2,
        KIND_VALUE = 2'd3
    } t_kind;

    typedef enum logic [StatusW-1:0] {
        ST_BUSY   = 3'd0,
        ST_OK     = 3'd1,
        ST_QEND   = 3'd2,
        ST_NOEQ   = 3'd3,
        ST_EQEND  = 3'd4,
        ST_NLVAL  = 3'd5,
        ST_AMPEND = 3'd6
    } t_status;

    typedef struct packed {
        t_phase      phase;
        logic [StatusW-1:0] error_code;
    } t_state;

    typedef struct packed {
        logic [CharW-1:0] char_out;
        t_kind            char_kind;
        logic             token_end;
        logic             pair_done;
        logic             string_done;
        logic [StatusW-1:0] status;
    } t_result;

    localparam t_state STATE_RESET = '{phase: PH_PATH, error_code: ST_BUSY};

endpackage

`default_nettype wire

// ===== hdl/uqt_if.sv =====
// Channel interfaces of the URL query tokenizer: the byte input channel and
// the tagged result channel. Depends on uqt_pkg for field widths.
`default_nettype none

interface uqt_in_if
    import uqt_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CharW-1:0] char_in;
    logic             last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface uqt_out_if
    import uqt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CharW-1:0]   char_out;
    logic [KindW-1:0]   char_kind;
    logic               token_end;
    logic               pair_done;
    logic               string_done;
    logic [StatusW-1:0] status;

    modport source (
        output valid, output char_out, output char_kind, output token_end,
        output pair_done, output string_done, output status, input ready
    );
    modport sink (
        input valid, input char_out, input char_kind, input token_end,
        input pair_done, input string_done, input status, output ready
    );
endinterface

`default_nettype wire

// ===== hdl/uqt_decode.sv =====
// Combinational byte decoder: from the current phase and one byte it forms
// the result and the next phase. Depends on uqt_pkg.
`default_nettype none

module uqt_decode
    import uqt_pkg::*;
(
    input  var t_state           i_state,
    input  var logic [CharW-1:0] i_char,
    input  var logic             i_last,
    output t_result              o_result,
    output t_state               o_next_state
);

    t_kind   w_kind;
    t_status w_status;
    logic    w_tend;
    logic    w_pdone;
    t_state  w_next;

    always_comb begin
        w_kind   = KIND_NONE;
        w_status = ST_BUSY;
        w_tend   = 1'b0;
        w_pdone  = 1'b0;
        w_next   = i_state;

        unique case (i_state.phase)
            PH_PATH: begin
                if (i_char == CHR_QMARK) begin
                    w_tend       = 1'b1;
                    w_next.phase = PH_NAME;
                    if (i_last) w_status = ST_QEND;
                end else begin
                    if (i_char != CHR_CR) w_kind = KIND_PATH;
                    if (i_last) begin
                        w_tend   = 1'b1;
                        w_status = ST_OK;
                    end
                end
            end
            PH_NAME: begin
                if (i_char == CHR_EQ) begin
                    w_tend       = 1'b1;
                    w_next.phase = PH_VALUE;
                    if (i_last) w_status = ST_EQEND;
                end else begin
                    if (i_char != CHR_CR) w_kind = KIND_NAME;
                    if (i_last) w_status = ST_NOEQ;
                end
            end
            PH_VALUE: begin
                if (i_char == CHR_AMP) begin
                    w_tend       = 1'b1;
                    w_pdone      = 1'b1;
                    w_next.phase = PH_NAME;
                    if (i_last) w_status = ST_AMPEND;
                end else if (i_char == CHR_LF) begin
                    // The pair still completes, but the rest of the string is skipped.
                    w_tend            = 1'b1;
                    w_pdone           = 1'b1;
                    w_next.phase      = PH_SKIP;
                    w_next.error_code = ST_NLVAL;
                    if (i_last) w_status = ST_NLVAL;
                end else begin
                    if (i_char != CHR_CR) w_kind = KIND_VALUE;
                    if (i_last) begin
                        w_tend   = 1'b1;
                        w_pdone  = 1'b1;
                        w_status = ST_OK;
                    end
                end
            end
            PH_SKIP: begin
                if (i_last) w_status = t_status'(i_state.error_code);
            end
            default: begin
                w_next = STATE_RESET;
            end
        endcase

        if (i_last) w_next = STATE_RESET;
    end

    assign o_result.char_out    = (w_kind != KIND_NONE) ? i_char : '0;
    assign o_result.char_kind   = w_kind;
    assign o_result.token_end   = w_tend;
    assign o_result.pair_done   = w_pdone;
    assign o_result.string_done = i_last;
    assign o_result.status      = w_status;
    assign o_next_state         = w_next;

endmodule

`default_nettype wire

// ===== hdl/url_query_tokenizer.sv =====
// Top level of the URL query tokenizer: input register, phase register,
// decoder and result register. Depends on uqt_pkg, uqt_if and uqt_decode.
//
// Usage:
// Bytes of a request path arrive one per transaction on i_in, with
// last_char set on the final byte of each string. Every input transaction
// yields exactly one result transaction on o_out, in order. A result tags
// the byte as path, name or value text (or none for delimiters, carriage
// returns and skipped bytes), flags the end of a token and of a finished
// name/value pair, and on the last byte reports the final status.
//
// An accepted byte is held in the input register, and the decoder runs
// between that register and the result register, updating the phase
// register in the same cycle as the result register loads. Throughput is
// one byte per cycle while the receiver takes results; the phase loop is a
// single decode step, so back-to-back strings need no gap.
//
// Reset clears both valid flags and returns the phase to path with no error.
// When the receiver stalls, the result register holds its transaction and
// the input register can still take one more byte; after that i_in.ready
// drops until the result is taken.
`default_nettype none

module url_query_tokenizer
    import uqt_pkg::*;
(
    input  var logic  i_clk,
    input  var logic  i_rst_n,
    uqt_in_if.sink    i_in,
    uqt_out_if.source o_out
);

    logic             r_in_valid;
    logic [CharW-1:0] r_in_char;
    logic             r_in_last;
    logic             r_out_valid;
    t_result          r_result;
    t_state           r_state;

    t_result          w_result;
    t_state           n_state;
    logic             w_advance;
    logic             w_in_ready;

    // The held byte moves on whenever the result register is empty or is
    // being emptied this cycle.
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_in.ready = w_in_ready;

    uqt_decode u_decode (
        .i_state      (r_state),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .o_result     (w_result),
        .o_next_state (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in_char <= i_in.char_in;
            r_in_last <= i_in.last_char;
        end
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_out    = r_result.char_out;
    assign o_out.char_kind   = r_result.char_kind;
    assign o_out.token_end   = r_result.token_end;
    assign o_out.pair_done   = r_result.pair_done;
    assign o_out.string_done = r_result.string_done;
    assign o_out.status      = r_result.status;

endmodule

`default_nettype wire

// ===== bench/url_query_tokenizer_test.sv =====
// Self-checking testbench for url_query_tokenizer: a directed table followed by
// random request strings, every result checked against the table or an in-bench tagger model.
// Depends on uqt_pkg, uqt_if and the url_query_tokenizer RTL.
`timescale 1ns / 100ps

module url_query_tokenizer_test;
    import uqt_pkg::*;

    localparam int unsigned ClkHalf     = 5;
    localparam int unsigned ResetCycles = 7;
    localparam int unsigned RandomBytes = 500;
    localparam int unsigned IdleLimit   = 2000;  // cycles with no transaction on either side
    localparam int unsigned HoldCycles  = 60;    // long receiver hold-off
    localparam int unsigned DrainCycles = 8;     // quiet cycles after the last result
    localparam int unsigned MaxReports  = 10;

    typedef struct {
        logic [CharW-1:0] ch;
        logic             last;
        bit               typed;
        t_result          res;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    uqt_in_if  in_ch ();
    uqt_out_if out_ch ();

    url_query_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Tagger model state, a copy of the phase machine of the block.
    t_phase             tok_phase;
    logic [StatusW-1:0] tok_err;

    t_result  pending_tags[$];
    t_dir_row dir_rows[$];
    logic [CharW-1:0] str_bytes[$];

    int sent_count;
    int result_count;
    int string_count;
    int mismatch_count;
    int status_seen[8];

    always begin
        #ClkHalf i_clk = 1'b1;
        #ClkHalf i_clk = 1'b0;
    end

    // Tags one byte the way the block should, and advances the model phase.
    function automatic t_result predict_token(input logic [CharW-1:0] c, input logic last);
        t_result r;
        t_phase  nxt;
        t_kind   k;
        r   = '0;
        k   = KIND_NONE;
        nxt = tok_phase;
        r.status = ST_BUSY;
        case (tok_phase)
            PH_PATH: begin
                if (c == CHR_QMARK) begin
                    r.token_end = 1'b1;
                    if (last) r.status = ST_QEND;
                    nxt = PH_NAME;
                end else begin
                    if (c != CHR_CR) k = KIND_PATH;
                    if (last) begin
                        r.token_end = 1'b1;
                        r.status    = ST_OK;
                    end
                end
            end
            PH_NAME: begin
                if (c == CHR_EQ) begin
                    r.token_end = 1'b1;
                    if (last) r.status = ST_EQEND;
                    nxt = PH_VALUE;
                end else begin
                    if (c != CHR_CR) k = KIND_NAME;
                    if (last) r.status = ST_NOEQ;
                end
            end
            PH_VALUE: begin
                if (c == CHR_AMP) begin
                    r.token_end = 1'b1;
                    r.pair_done = 1'b1;
                    if (last) r.status = ST_AMPEND;
                    nxt = PH_NAME;
                end else if (c == CHR_LF) begin
                    // A newline still closes the pair, but the rest of the string is skipped.
                    r.token_end = 1'b1;
                    r.pair_done = 1'b1;
                    tok_err = ST_NLVAL;
                    if (last) r.status = ST_NLVAL;
                    nxt = PH_SKIP;
                end else begin
                    if (c != CHR_CR) k = KIND_VALUE;
                    if (last) begin
                        r.token_end = 1'b1;
                        r.pair_done = 1'b1;
                        r.status    = ST_OK;
                    end
                end
            end
            default: begin
                if (last) r.status = tok_err;
            end
        endcase
        if (last) begin
            nxt     = PH_PATH;
            tok_err = ST_BUSY;
        end
        tok_phase     = nxt;
        r.char_kind   = k;
        r.char_out    = (k != KIND_NONE) ? c : '0;
        r.string_done = last;
        return r;
    endfunction

    function automatic t_result mk_res(input logic [CharW-1:0] ch, input t_kind k,
                                       input logic te, input logic pd, input logic sd,
                                       input t_status st);
        t_result r;
        r.char_out    = ch;
        r.char_kind   = k;
        r.token_end   = te;
        r.pair_done   = pd;
        r.string_done = sd;
        r.status      = st;
        return r;
    endfunction

    task automatic add_row(input logic [CharW-1:0] ch, input logic last, input bit typed,
                           input t_result res);
        t_dir_row row;
        row.ch    = ch;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        dir_rows.push_back(row);
    endtask

    // Mostly no gap, sometimes a few cycles, rarely a long one. A calm stretch
    // forces a run of back-to-back cycles.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Token text: mostly letters, some arbitrary bytes, a few carriage returns.
    // The banned bytes would end the token early, so they are redrawn.
    function automatic logic [CharW-1:0] text_byte(input logic [CharW-1:0] ban_a,
                                                   input logic [CharW-1:0] ban_b);
        logic [CharW-1:0] b;
        int r;
        b = ban_a;
        while (b == ban_a || b == ban_b) begin
            r = $urandom_range(0, 99);
            if (r < 60) b = 8'h61 + CharW'($urandom_range(0, 25));
            else if (r < 94) b = CharW'($urandom_range(0, 255));
            else b = CHR_CR;
        end
        return b;
    endfunction

    // Builds one request string in str_bytes: mostly well formed, with an
    // occasional error ending and some pure noise.
    task automatic build_string();
        int mode;
        int err;
        int npairs;
        int n;
        str_bytes.delete();
        mode = $urandom_range(0, 99);
        if (mode < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: str_bytes.push_back(CHR_QMARK);
                    1: str_bytes.push_back(CHR_EQ);
                    2: str_bytes.push_back(CHR_AMP);
                    3: str_bytes.push_back(CHR_LF);
                    default: str_bytes.push_back(CharW'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        n = $urandom_range(0, 4);
        repeat (n) str_bytes.push_back(text_byte(CHR_QMARK, CHR_QMARK));
        if (mode < 18) begin
            if (str_bytes.size() == 0) str_bytes.push_back(8'h2F);
            return;
        end
        str_bytes.push_back(CHR_QMARK);
        err = $urandom_range(0, 10);
        if (err == 6) return;
        npairs = $urandom_range(1, 3);
        for (int p = 0; p < npairs; p++) begin
            n = $urandom_range(0, 3);
            repeat (n) str_bytes.push_back(text_byte(CHR_EQ, CHR_EQ));
            if (err == 7 && p == npairs - 1) begin
                str_bytes.push_back(8'h6E);
                return;
            end
            str_bytes.push_back(CHR_EQ);
            if (err == 8 && p == npairs - 1) return;
            n = $urandom_range(0, 3);
            repeat (n) str_bytes.push_back(text_byte(CHR_AMP, CHR_LF));
            if (err == 9 && p == npairs - 1) begin
                str_bytes.push_back(CHR_LF);
                n = $urandom_range(0, 3);
                repeat (n) str_bytes.push_back(CharW'($urandom_range(0, 255)));
                return;
            end
            if (p < npairs - 1) str_bytes.push_back(CHR_AMP);
        end
        if (err == 10) str_bytes.push_back(CHR_AMP);
    endtask

    int send_calm;

    // Offers one byte after a random gap and waits for the transaction. The
    // expected tags are queued at the edge where the byte is taken.
    task automatic send_byte(input logic [CharW-1:0] ch, input logic last, input bit typed,
                             input t_result typed_res);
        int gap;
        t_result pred;
        gap = pick_gap(send_calm);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid     <= 1'b1;
        in_ch.char_in   <= ch;
        in_ch.last_char <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pred = predict_token(ch, last);
        pending_tags.push_back(typed ? typed_res : pred);
        sent_count++;
    endtask

    // Sender: reset, the directed table, then random strings.
    initial begin
        bit paused;
        in_ch.valid     = 1'b0;
        in_ch.char_in   = '0;
        in_ch.last_char = 1'b0;
        i_rst_n         = 1'b0;
        i_clk           = 1'b0;
        tok_phase       = PH_PATH;
        tok_err         = ST_BUSY;
        sent_count      = 0;
        send_calm       = 0;
        paused          = 1'b0;

        // Extremes of the byte, each error ending, and delimiters used as text.
        add_row(8'h00, 1'b1, 1'b1, mk_res(8'h00, KIND_PATH, 1'b1, 1'b0, 1'b1, ST_OK));
        add_row(8'hFF, 1'b1, 1'b1, mk_res(8'hFF, KIND_PATH, 1'b1, 1'b0, 1'b1, ST_OK));
        add_row(CHR_CR, 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b1, 1'b0, 1'b1, ST_OK));
        add_row(CHR_QMARK, 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b1, 1'b0, 1'b1, ST_QEND));
        add_row(8'h2F, 1'b0, 1'b0, '0);
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row(CHR_EQ, 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b1, 1'b0, 1'b1, ST_EQEND));
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row(CHR_AMP, 1'b0, 1'b0, '0);
        add_row(CHR_LF, 1'b0, 1'b0, '0);
        add_row(CHR_EQ, 1'b0, 1'b0, '0);
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row(CHR_EQ, 1'b0, 1'b0, '0);
        add_row(CHR_AMP, 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b1, 1'b1, 1'b1, ST_AMPEND));
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row("n", 1'b1, 1'b1, mk_res("n", KIND_NAME, 1'b0, 1'b0, 1'b1, ST_NOEQ));
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row(CHR_EQ, 1'b0, 1'b0, '0);
        add_row(CHR_LF, 1'b0, 1'b0, '0);
        add_row("z", 1'b0, 1'b0, '0);
        add_row("q", 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b0, 1'b0, 1'b1, ST_NLVAL));
        add_row(CHR_QMARK, 1'b0, 1'b0, '0);
        add_row("k", 1'b0, 1'b0, '0);
        add_row(CHR_EQ, 1'b0, 1'b0, '0);
        add_row(CHR_CR, 1'b1, 1'b1, mk_res(8'h00, KIND_NONE, 1'b1, 1'b1, 1'b1, ST_OK));

        repeat (ResetCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
        end

        while (sent_count < dir_rows.size() + RandomBytes) begin
            // Once, in the middle of the run, let the block drain completely.
            if (!paused && sent_count >= 350) begin
                paused = 1'b1;
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                while (pending_tags.size() != 0) @(posedge i_clk);
            end
            build_string();
            foreach (str_bytes[i]) begin
                send_byte(str_bytes[i], (i == str_bytes.size() - 1), 1'b0, '0);
            end
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b0;

        while (pending_tags.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings, checked %0d results.",
                 sent_count, string_count, result_count);
        $display("Final status counts: ok %0d, end after ? %0d, no = %0d, end after = %0d, newline %0d, end after & %0d.",
                 status_seen[ST_OK], status_seen[ST_QEND], status_seen[ST_NOEQ],
                 status_seen[ST_EQEND], status_seen[ST_NLVAL], status_seen[ST_AMPEND]);
        if (mismatch_count == 0 && pending_tags.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Receiver: random gaps, plus one long hold-off while the sender keeps
    // offering bytes, so the block fills up and drops its input ready.
    initial begin
        int  recv_calm;
        int  gap_left;
        bit  held;
        out_ch.ready = 1'b0;
        recv_calm    = 0;
        gap_left     = 0;
        held         = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sent_count >= 200) begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HoldCycles - 1) begin
                    @(negedge i_clk);
                    out_ch.ready <= 1'b0;
                end
            end else if (gap_left > 0) begin
                out_ch.ready <= 1'b0;
                gap_left--;
            end else begin
                out_ch.ready <= 1'b1;
                gap_left = pick_gap(recv_calm);
            end
        end
    end

    // Result checker: each result transaction is matched to the oldest expectation.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.char_out    = out_ch.char_out;
            got.char_kind   = t_kind'(out_ch.char_kind);
            got.token_end   = out_ch.token_end;
            got.pair_done   = out_ch.pair_done;
            got.string_done = out_ch.string_done;
            got.status      = out_ch.status;
            result_count++;
            if (pending_tags.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MaxReports) begin
                    $display("ERROR: result with no expectation: char=%h kind=%0d end=%b pair=%b done=%b status=%0d",
                             got.char_out, got.char_kind, got.token_end, got.pair_done,
                             got.string_done, got.status);
                end
            end else begin
                want = pending_tags.pop_front();
                if (got.char_out !== want.char_out || got.char_kind !== want.char_kind ||
                    got.token_end !== want.token_end || got.pair_done !== want.pair_done ||
                    got.string_done !== want.string_done || got.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MaxReports) begin
                        $display("ERROR: result %0d: expected char=%h kind=%0d end=%b pair=%b done=%b status=%0d",
                                 result_count, want.char_out, want.char_kind, want.token_end,
                                 want.pair_done, want.string_done, want.status);
                        $display("       got            char=%h kind=%0d end=%b pair=%b done=%b status=%0d",
                                 got.char_out, got.char_kind, got.token_end, got.pair_done,
                                 got.string_done, got.status);
                    end
                end
                if (want.string_done) begin
                    string_count++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either channel is a hang.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
            else idle++;
            if (idle >= IdleLimit) begin
                $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
                         idle, pending_tags.size());
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
